### src/srecord_s19_encoder_unit_defines.svh
// Assertion macros shared by the S-record encoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SRECORD_S19_ENCODER_UNIT_DEFINES_SVH
`define SRECORD_S19_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SREC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srec assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SREC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srec assertion failed");

`endif

### src/srec_pkg.sv
// Shared types, codes and character tables of the S-record encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package srec_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOAD_ADDR  = 2'd0;
  localparam logic [1:0] CFG_ENTRY_ADDR = 2'd1;
  localparam logic [1:0] CFG_BYTE_COUNT = 2'd2;

  // Input function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  localparam logic [6:0] CH_NL = 7'h0A;
  localparam logic [6:0] CH_S  = 7'h53;
  localparam int unsigned S0_LEN = 17;

  // One input transaction.
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  // One output character transaction.
  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
    logic       image_done;
  } out_item_t;

  // Work for the back end, as classified by the front end.
  typedef struct packed {
    logic        has_s0;
    logic        has_hdr;
    logic        has_data;
    logic        has_tail;
    logic        has_s9;
    logic [7:0]  count;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  csum;
  } job_t;

  // Uppercase hex digit of a nibble.
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c[6:0];
  endfunction

  // Fixed S0 header line, one character per index.
  function automatic logic [6:0] s0_char(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = "S";
      5'd1:    c = "0";
      5'd2:    c = "0";
      5'd3:    c = "6";
      5'd4:    c = "0";
      5'd5:    c = "0";
      5'd6:    c = "0";
      5'd7:    c = "0";
      5'd8:    c = "4";
      5'd9:    c = "8";
      5'd10:   c = "4";
      5'd11:   c = "4";
      5'd12:   c = "5";
      5'd13:   c = "2";
      5'd14:   c = "1";
      5'd15:   c = "B";
      5'd16:   c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c[6:0];
  endfunction

endpackage

`default_nettype wire

### src/srec_front.sv
// Front end: accepts input transactions, tracks the image and line state,
// and turns each item into a job for the back end. Uses srec_pkg.
`default_nettype none

module srec_front import srec_pkg::*; #(
  parameter int MAX_LINE_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire in_item_t    item,
  output logic             item_stall,
  input  wire logic [15:0] load_address,
  input  wire logic [15:0] byte_count,
  input  wire logic        queue_full,
  output logic             push,
  output job_t             push_job
);

  localparam int LW = $clog2(MAX_LINE_BYTES + 1);

  logic          active;
  logic [15:0]   bytes_remaining;
  logic [15:0]   current_address;
  logic [LW-1:0] bytes_left_in_line;
  logic [7:0]    running_sum;

  logic          accept;
  logic          line_open;
  logic [LW-1:0] size;
  logic [7:0]    count;
  logic [7:0]    base_sum;
  logic [7:0]    new_sum;
  logic [LW-1:0] left_next;
  logic [15:0]   remaining_next;

  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;

  // Line bookkeeping for a data byte.
  always_comb begin
    line_open = (bytes_left_in_line != '0);
    if (bytes_remaining > 16'(MAX_LINE_BYTES)) begin
      size = LW'(MAX_LINE_BYTES);
    end else begin
      size = bytes_remaining[LW-1:0];
    end
    count          = 8'(size) + 8'd3;
    base_sum       = line_open ? running_sum
                               : count + current_address[15:8] + current_address[7:0];
    new_sum        = base_sum + item.data_byte;
    left_next      = (line_open ? bytes_left_in_line : size) - LW'(1);
    remaining_next = bytes_remaining - 16'd1;
  end

  // Job classification.
  always_comb begin
    push_job          = '0;
    push              = 1'b0;
    if (item.func == FUNC_START) begin
      push            = accept;
      push_job.has_s0 = 1'b1;
      push_job.has_s9 = (byte_count == 16'd0);
    end else begin
      push              = accept && active;
      push_job.has_hdr  = !line_open;
      push_job.has_data = 1'b1;
      push_job.has_tail = (left_next == '0);
      push_job.has_s9   = (remaining_next == 16'd0);
      push_job.count    = count;
      push_job.addr     = current_address;
      push_job.data     = item.data_byte;
      push_job.csum     = ~new_sum;
    end
  end

  // Image state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      active             <= 1'b0;
      bytes_remaining    <= '0;
      current_address    <= '0;
      bytes_left_in_line <= '0;
      running_sum        <= '0;
    end else if (accept) begin
      if (item.func == FUNC_START) begin
        active             <= (byte_count != 16'd0);
        bytes_remaining    <= byte_count;
        current_address    <= load_address;
        bytes_left_in_line <= '0;
        running_sum        <= '0;
      end else if (active) begin
        running_sum        <= new_sum;
        bytes_remaining    <= remaining_next;
        current_address    <= current_address + 16'd1;
        active             <= (remaining_next != 16'd0);
        bytes_left_in_line <= (remaining_next == 16'd0) ? '0 : left_next;
      end
    end
  end

`include "srecord_s19_encoder_unit_defines.svh"

  `SREC_ASSERT_NOW(a_active_has_bytes, clk, rst, active, bytes_remaining != 16'd0)

endmodule

`default_nettype wire

### src/srec_queue.sv
// Short job queue between the front end and the back end.
// Uses srec_pkg for the job type.
`default_nettype none

module srec_queue import srec_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_job   = slots[rd_ptr];

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

`include "srecord_s19_encoder_unit_defines.svh"

  `SREC_ASSERT_NOW(a_no_overflow, clk, rst, push, !full || pop)
  `SREC_ASSERT_NOW(a_no_underflow, clk, rst, pop, not_empty)

endmodule

`default_nettype wire

### src/srec_back.sv
// Back end: walks each job through its S-record segments and emits one
// character per cycle, unless the output stalls, into an output register. Uses srec_pkg.
`default_nettype none

module srec_back import srec_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] entry_address,
  input  wire logic        queue_valid,
  input  wire job_t        queue_job,
  output logic             pop,
  output logic             text_valid,
  input  wire logic        text_stall,
  output out_item_t        text
);

  typedef enum logic [2:0] {
    PH_S0,
    PH_HDR,
    PH_DATA,
    PH_TAIL,
    PH_S9
  } phase_t;

  job_t       cur;
  logic       cur_valid;
  phase_t     phase;
  logic [4:0] idx;

  phase_t     first_phase;
  phase_t     nxt_phase;
  logic       nxt_valid;
  logic [4:0] plen;
  logic       phase_end;
  logic       job_end;
  logic       slot_free;
  logic       emit;
  logic [6:0] ch;
  logic [7:0] s9_csum;

  assign s9_csum   = ~(8'd3 + entry_address[15:8] + entry_address[7:0]);
  assign slot_free = !text_valid || !text_stall;
  assign emit      = cur_valid && slot_free;
  assign phase_end = (idx == plen - 5'd1);
  assign job_end   = phase_end && !nxt_valid;
  assign pop       = queue_valid && (!cur_valid || (emit && job_end));

  // Segment lengths and ordering.
  always_comb begin
    unique case (phase)
      PH_S0:   plen = 5'(S0_LEN);
      PH_HDR:  plen = 5'd8;
      PH_DATA: plen = 5'd2;
      PH_TAIL: plen = 5'd3;
      PH_S9:   plen = 5'd11;
      default: plen = 5'd1;
    endcase

    nxt_valid = 1'b0;
    nxt_phase = PH_S9;
    unique case (phase)
      PH_S0: begin
        nxt_valid = cur.has_s9;
      end
      PH_HDR: begin
        nxt_valid = 1'b1;
        nxt_phase = PH_DATA;
      end
      PH_DATA: begin
        nxt_valid = cur.has_tail || cur.has_s9;
        nxt_phase = cur.has_tail ? PH_TAIL : PH_S9;
      end
      PH_TAIL: begin
        nxt_valid = cur.has_s9;
      end
      default: begin
        nxt_valid = 1'b0;
      end
    endcase

    priority if (queue_job.has_s0) begin
      first_phase = PH_S0;
    end else if (queue_job.has_hdr) begin
      first_phase = PH_HDR;
    end else begin
      first_phase = PH_DATA;
    end
  end

  // Character of the current segment position.
  always_comb begin
    ch = CH_NL;
    unique case (phase)
      PH_S0: begin
        ch = s0_char(idx);
      end
      PH_HDR: begin
        unique case (idx)
          5'd0:    ch = CH_S;
          5'd1:    ch = hex_char(4'd1);
          5'd2:    ch = hex_char(cur.count[7:4]);
          5'd3:    ch = hex_char(cur.count[3:0]);
          5'd4:    ch = hex_char(cur.addr[15:12]);
          5'd5:    ch = hex_char(cur.addr[11:8]);
          5'd6:    ch = hex_char(cur.addr[7:4]);
          default: ch = hex_char(cur.addr[3:0]);
        endcase
      end
      PH_DATA: begin
        ch = (idx == 5'd0) ? hex_char(cur.data[7:4]) : hex_char(cur.data[3:0]);
      end
      PH_TAIL: begin
        unique case (idx)
          5'd0:    ch = hex_char(cur.csum[7:4]);
          5'd1:    ch = hex_char(cur.csum[3:0]);
          default: ch = CH_NL;
        endcase
      end
      PH_S9: begin
        unique case (idx)
          5'd0:    ch = CH_S;
          5'd1:    ch = hex_char(4'd9);
          5'd2:    ch = hex_char(4'd0);
          5'd3:    ch = hex_char(4'd3);
          5'd4:    ch = hex_char(entry_address[15:12]);
          5'd5:    ch = hex_char(entry_address[11:8]);
          5'd6:    ch = hex_char(entry_address[7:4]);
          5'd7:    ch = hex_char(entry_address[3:0]);
          5'd8:    ch = hex_char(s9_csum[7:4]);
          5'd9:    ch = hex_char(s9_csum[3:0]);
          default: ch = CH_NL;
        endcase
      end
      default: begin
        ch = CH_NL;
      end
    endcase
  end

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      phase      <= PH_S0;
      idx        <= '0;
      text_valid <= 1'b0;
    end else begin
      if (emit) begin
        text_valid <= 1'b1;
      end else if (slot_free) begin
        text_valid <= 1'b0;
      end

      if (pop) begin
        cur_valid <= 1'b1;
        phase     <= first_phase;
        idx       <= '0;
      end else if (emit) begin
        if (job_end) begin
          cur_valid <= 1'b0;
        end else if (phase_end) begin
          phase <= nxt_phase;
          idx   <= '0;
        end else begin
          idx <= idx + 5'd1;
        end
      end
    end
  end

  // Output payload; no reset needed.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= queue_job;
    end
    if (emit) begin
      text.out_char   <= ch;
      text.run_last   <= job_end;
      text.image_done <= job_end && (phase == PH_S9);
    end
  end

`include "srecord_s19_encoder_unit_defines.svh"

  `SREC_ASSERT_NOW(a_idx_in_range, clk, rst, cur_valid, idx < plen)
  `SREC_ASSERT_NOW(a_done_is_newline, clk, rst, text_valid && text.image_done,
                   text.run_last && (text.out_char == CH_NL))

endmodule

`default_nettype wire

### src/srecord_s19_encoder_unit.sv
// Motorola S-record (S19) encoder: one character per output transaction.
// The first character of an item passes the job queue, the current job and the output registers.
// Throughput: one character per cycle unless the output stalls; an item emits 2 characters for a
// mid-line byte, 10 to open a line, 13 to open and close it, up to 24 with the S9 line.
// A start emits 17, or 28 with the S9 line; a four-entry job queue decouples input and output.
// Reset (synchronous) clears configuration, image state, queue and output valid.
`default_nettype none

module srecord_s19_encoder_unit import srec_pkg::*; #(
  parameter int MAX_LINE_BYTES = 16,
  parameter int QUEUE_DEPTH    = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire in_item_t    data,
  output logic             text_valid,
  input  wire logic        text_stall,
  output out_item_t        text,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] load_address;
  logic [15:0] entry_address;
  logic [15:0] byte_count;

  logic q_full;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  job_t q_pop_job;
  logic q_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_address  <= '0;
      entry_address <= '0;
      byte_count    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOAD_ADDR:  load_address  <= cfg_data;
        CFG_ENTRY_ADDR: entry_address <= cfg_data;
        CFG_BYTE_COUNT: byte_count    <= cfg_data;
        default:        ;
      endcase
    end
  end

  srec_front #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (data_valid),
    .item        (data),
    .item_stall  (data_stall),
    .load_address(load_address),
    .byte_count  (byte_count),
    .queue_full  (q_full),
    .push        (q_push),
    .push_job    (q_push_job)
  );

  srec_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .not_empty(q_valid)
  );

  srec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .entry_address(entry_address),
    .queue_valid  (q_valid),
    .queue_job    (q_pop_job),
    .pop          (q_pop),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text         (text)
  );

endmodule

`default_nettype wire
